// ===== hdl/ttie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttie_pkg
// Shared constants and types of the triangle index expander: topology codes,
// index and counter widths, and the command passed from front to back end.
// ----------------------------------------------------------------------------
package ttie_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int VPOS_W       = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W        = 17;
    localparam int PRIM_W       = 5;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PRIM_W-1:0] PRIM_FAN        = PRIM_W'(5);
    localparam logic [PRIM_W-1:0] PRIM_RECT_LIST  = PRIM_W'(8);
    localparam logic [PRIM_W-1:0] PRIM_QUAD_LIST  = PRIM_W'(13);
    localparam logic [PRIM_W-1:0] PRIM_QUAD_STRIP = PRIM_W'(14);
    localparam logic [PRIM_W-1:0] PRIM_POLYGON    = PRIM_W'(15);

    typedef enum logic [1:0] {
        CMD_FAN,
        CMD_RECT,
        CMD_QUAD,
        CMD_STRIP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  base;
    } tri_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

// ===== hdl/ttie_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttie_front
// Accepts vertex beats, tracks count, group phase and group base, and pushes
// one command per vertex that closes a primitive.
// ----------------------------------------------------------------------------
module ttie_front
    import ttie_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [PRIM_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              start_of_draw,
    input  wire queue_status_t     q_status,
    output logic                   push,
    output tri_cmd_t               push_cmd
);

    logic [PRIM_W-1:0] prim_reg;
    logic [VPOS_W-1:0] pos_reg, pos_next;
    logic [1:0]        phase_reg, phase_next;
    logic [IDX_W-1:0]  base_reg, base_next;

    logic [VPOS_W-1:0] eff_pos;
    logic [1:0]        eff_phase;
    logic [IDX_W-1:0]  eff_base;
    logic [IDX_W-1:0]  pos_idx;
    logic              accept;
    logic              emit;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            prim_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        eff_pos    = start_of_draw ? '0 : pos_reg;
        eff_phase  = start_of_draw ? '0 : phase_reg;
        eff_base   = start_of_draw ? '0 : base_reg;
        pos_idx    = IDX_W'(eff_pos);
        pos_next   = eff_pos;
        phase_next = eff_phase;
        base_next  = eff_base;
        emit       = 1'b0;
        push_cmd   = '{kind: CMD_FAN, base: pos_idx};
        if (eff_pos != VPOS_W'(MAX_VERTICES))
        begin
            pos_next = eff_pos + VPOS_W'(1);
            case (prim_reg) inside
                PRIM_FAN, PRIM_POLYGON:
                begin
                    emit = (eff_pos >= VPOS_W'(2));
                end
                PRIM_RECT_LIST:
                begin
                    push_cmd.kind = CMD_RECT;
                    push_cmd.base = eff_base;
                    if (eff_phase >= 2'd2)
                    begin
                        emit       = 1'b1;
                        phase_next = 2'd0;
                        base_next  = eff_base + IDX_W'(4);
                    end
                    else
                    begin
                        phase_next = eff_phase + 2'd1;
                    end
                end
                PRIM_QUAD_LIST:
                begin
                    push_cmd.kind = CMD_QUAD;
                    push_cmd.base = eff_base;
                    if (eff_phase == 2'd3)
                    begin
                        emit      = 1'b1;
                        base_next = eff_base + IDX_W'(4);
                    end
                    phase_next = eff_phase + 2'd1;
                end
                PRIM_QUAD_STRIP:
                begin
                    push_cmd.kind = CMD_STRIP;
                    push_cmd.base = pos_idx - IDX_W'(3);
                    emit = (eff_pos >= VPOS_W'(3)) && eff_pos[0];
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
            base_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            base_reg  <= base_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ttie_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttie_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module ttie_queue
    import ttie_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire tri_cmd_t push_cmd,
    input  wire logic     pop,
    output tri_cmd_t      head_cmd,
    output queue_status_t status
);

    tri_cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;

    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QUEUE_CW'(1);
                2'b01:   count_reg <= count_reg - QUEUE_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ttie_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttie_back
// Expands queued commands into triangle beats through an output register.
// ----------------------------------------------------------------------------
module ttie_back
    import ttie_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tri_cmd_t       head_cmd,
    input  wire queue_status_t  q_status,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [IDX_W-1:0]    corner_a,
    output logic [IDX_W-1:0]    corner_b,
    output logic [IDX_W-1:0]    corner_c,
    output logic                last_of_run
);

    logic             valid_reg, valid_next;
    logic             half_reg, half_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic             last_reg, last_next;

    logic             load;
    logic [IDX_W-1:0] bm1, b0, bp1, bp2, bp3;

    assign load = !valid_reg || out_ready;

    always_comb
    begin
        b0  = head_cmd.base;
        bm1 = b0 - IDX_W'(1);
        bp1 = b0 + IDX_W'(1);
        bp2 = b0 + IDX_W'(2);
        bp3 = b0 + IDX_W'(3);

        valid_next = valid_reg && !out_ready;
        half_next  = half_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (load && !q_status.empty)
        begin
            valid_next = 1'b1;
            last_next  = half_reg || (head_cmd.kind == CMD_FAN);
            pop        = last_next;
            half_next  = !last_next;
            unique case (head_cmd.kind)
                CMD_FAN:
                begin
                    a_next = '0;
                    b_next = bm1;
                    c_next = b0;
                end
                CMD_RECT:
                begin
                    a_next = half_reg ? bp1 : b0;
                    b_next = half_reg ? bp3 : bp1;
                    c_next = bp2;
                end
                CMD_QUAD:
                begin
                    a_next = b0;
                    b_next = half_reg ? bp2 : bp1;
                    c_next = half_reg ? bp3 : bp2;
                end
                CMD_STRIP:
                begin
                    a_next = b0;
                    b_next = half_reg ? bp3 : bp1;
                    c_next = half_reg ? bp2 : bp3;
                end
                default:
                begin
                    a_next = b0;
                    b_next = bp1;
                    c_next = bp2;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign corner_a    = a_reg;
    assign corner_b    = b_reg;
    assign corner_c    = c_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

// ===== hdl/topology_to_triangle_index_expander_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// topology_to_triangle_index_expander_unit
// Expands fan, polygon, rect list, quad list and quad strip vertex streams
// into triangle-list corner indices.
// ----------------------------------------------------------------------------
// One vertex beat is taken per cycle while the four-entry command queue has
// room; the front end updates the vertex count and group state in that same
// cycle. A vertex that closes a primitive queues one command, which the back
// end turns into one triangle beat (fan, polygon) or two beats (rect list,
// quad list, quad strip) through its output register; the command is
// registered in the queue and then in the output register before a result
// appears. Sustained throughput is one vertex per cycle for every topology
// while out_ready stays high; bursts of paired triangles are absorbed by the
// queue. Write the topology register only while idle.
module topology_to_triangle_index_expander_unit
    import ttie_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [PRIM_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              start_of_draw,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IDX_W-1:0]       corner_a,
    output logic [IDX_W-1:0]       corner_b,
    output logic [IDX_W-1:0]       corner_c,
    output logic                   last_of_run
);

    queue_status_t q_status;
    tri_cmd_t      push_cmd;
    tri_cmd_t      head_cmd;
    logic          push;
    logic          pop;

    ttie_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_of_draw (start_of_draw),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    ttie_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    ttie_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .corner_a    (corner_a),
        .corner_b    (corner_b),
        .corner_c    (corner_c),
        .last_of_run (last_of_run)
    );

endmodule
`default_nettype wire
